### sv/rgb565_linear_gradient_generator_defines.svh
// ----------------------------------------------------------------------------
// RGB565 gradient generator assertion macros
// Shared assertion forms for the gradient generator checker.
// ----------------------------------------------------------------------------
`ifndef RGB565_LINEAR_GRADIENT_GENERATOR_DEFINES_SVH
`define RGB565_LINEAR_GRADIENT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define RGBGRAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBGRAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rgbgrad_pkg.sv
// ----------------------------------------------------------------------------
// rgbgrad_pkg
// Types, constants and helpers for the RGB565 gradient generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbgrad_pkg;

  localparam int COLOR_W     = 16;
  localparam int AW_W        = 10;
  localparam int AH_W        = 8;
  localparam int COL_OUT_W   = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CH_W        = 6;
  localparam int CH5_W       = 5;
  localparam int AW_MAX      = (1 << AW_W) - 1;
  localparam int MAX_WIDTH_DEF = 512;

  // divider: |quotient| <= max channel delta, so QB bits suffice
  localparam int QB          = 6;
  localparam int NUM_W       = 18;
  localparam int MAG_W       = NUM_W - 1;
  localparam int STEP_W      = $clog2(QB);

  localparam logic [COLOR_W-1:0] RED_MASK = 16'hF800;
  localparam logic [COLOR_W-1:0] GRN_MASK = 16'h07E0;
  localparam logic [COLOR_W-1:0] BLU_MASK = 16'h001F;
  localparam logic [CH_W-1:0]    CH5_MASK = 6'h1F;
  localparam int RED_SHIFT = 11;
  localparam int GRN_SHIFT = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_COLOR    = 3'd0,
    REG_BOTTOM_COLOR = 3'd1,
    REG_AREA_WIDTH   = 3'd2,
    REG_AREA_HEIGHT  = 3'd3,
    REG_DIRECTION    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_PREP,
    G_ISSUE,
    G_WAIT,
    G_EMIT
  } gen_state_t;

  typedef enum logic [1:0] {
    LS_IDLE,
    LS_MUL,
    LS_DIV
  } lerp_state_t;

  typedef struct packed {
    logic            go;
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] b;
    logic [AW_W-1:0] i;
    logic [AW_W-1:0] n;
  } lerp_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] value;
  } lerp_rsp_t;

  function automatic logic [CH_W-1:0] chan_field(input logic [COLOR_W-1:0] c,
                                                 input chan_t ch);
    logic [CH_W-1:0] f;
    unique case (ch)
      CH_RED:   f = CH_W'((c & RED_MASK) >> RED_SHIFT);
      CH_GREEN: f = CH_W'((c & GRN_MASK) >> GRN_SHIFT);
      CH_BLUE:  f = CH_W'(c & BLU_MASK);
      default:  f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

### sv/rgbgrad_ifs.sv
// ----------------------------------------------------------------------------
// rgbgrad interfaces
// Request and pixel channels of the gradient generator.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbgrad_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rgbgrad_pix_if;
  logic                                  valid;
  logic                                  ready;
  logic [rgbgrad_pkg::COLOR_W-1:0]       pixel_color;
  logic [rgbgrad_pkg::COL_OUT_W-1:0]     column;
  logic [rgbgrad_pkg::AH_W-1:0]          row;
  logic                                  last_pixel;

  modport source (output valid, output pixel_color, output column, output row,
                  output last_pixel, input ready);
  modport sink   (input valid, input pixel_color, input column, input row,
                  input last_pixel, output ready);
endinterface

`default_nettype wire

### sv/rgbgrad_lerp.sv
// ----------------------------------------------------------------------------
// rgbgrad_lerp
// Shared channel interpolator: one multiply, then a restoring divide that
// retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbgrad_lerp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rgbgrad_pkg::lerp_req_t req,
  output rgbgrad_pkg::lerp_rsp_t     rsp
);

  rgbgrad_pkg::lerp_state_t state, state_next;

  logic [rgbgrad_pkg::CH_W-1:0]   a, b;
  logic [rgbgrad_pkg::AW_W-1:0]   i, n;
  logic                           neg;
  logic [rgbgrad_pkg::MAG_W-1:0]  rem, dvs;
  logic [rgbgrad_pkg::QB-1:0]     q;
  logic [rgbgrad_pkg::STEP_W-1:0] step;
  logic                           done;
  logic [rgbgrad_pkg::CH_W-1:0]   value;

  logic signed [rgbgrad_pkg::CH_W:0]    delta;
  logic signed [rgbgrad_pkg::NUM_W-1:0] delta_x, i_x, prod, num, num_abs;
  logic                                 ge;
  logic [rgbgrad_pkg::QB-1:0]           q_fin;
  logic [rgbgrad_pkg::CH_W+1:0]         q_ext, sum;

  assign delta   = $signed({1'b0, b}) - $signed({1'b0, a});
  assign delta_x = rgbgrad_pkg::NUM_W'(delta);
  assign i_x     = $signed(rgbgrad_pkg::NUM_W'(i));
  assign prod    = delta_x * i_x;
  assign num     = prod + $signed(rgbgrad_pkg::NUM_W'(n >> 1));
  assign num_abs = num[rgbgrad_pkg::NUM_W-1] ? -num : num;

  assign ge    = (rem >= dvs);
  assign q_fin = {q[rgbgrad_pkg::QB-2:0], ge};
  assign q_ext = (rgbgrad_pkg::CH_W+2)'(q_fin);
  assign sum   = (rgbgrad_pkg::CH_W+2)'(a) + (neg ? -q_ext : q_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgbgrad_pkg::LS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rgbgrad_pkg::LS_DIV) && (step == rgbgrad_pkg::STEP_W'(rgbgrad_pkg::QB - 1));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rgbgrad_pkg::LS_IDLE: begin
        if (req.go) begin
          a <= req.a;
          b <= req.b;
          i <= req.i;
          n <= req.n;
        end
      end
      rgbgrad_pkg::LS_MUL: begin
        neg  <= num[rgbgrad_pkg::NUM_W-1];
        rem  <= num_abs[rgbgrad_pkg::MAG_W-1:0];
        dvs  <= rgbgrad_pkg::MAG_W'(n) << (rgbgrad_pkg::QB - 1);
        q    <= '0;
        step <= '0;
      end
      rgbgrad_pkg::LS_DIV: begin
        if (ge) begin
          rem <= rem - dvs;
        end
        dvs  <= dvs >> 1;
        q    <= q_fin;
        step <= step + 1'b1;
        if (step == rgbgrad_pkg::STEP_W'(rgbgrad_pkg::QB - 1)) begin
          value <= sum[rgbgrad_pkg::CH_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rgbgrad_pkg::LS_IDLE: if (req.go) state_next = rgbgrad_pkg::LS_MUL;
      rgbgrad_pkg::LS_MUL:  state_next = rgbgrad_pkg::LS_DIV;
      rgbgrad_pkg::LS_DIV: begin
        if (step == rgbgrad_pkg::STEP_W'(rgbgrad_pkg::QB - 1)) begin
          state_next = rgbgrad_pkg::LS_IDLE;
        end
      end
      default: state_next = rgbgrad_pkg::LS_IDLE;
    endcase
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

`default_nettype wire

### sv/rgb565_linear_gradient_generator.sv
// ----------------------------------------------------------------------------
// rgb565_linear_gradient_generator
// Streams the pixels of a rectangle filled with a linear RGB565 gradient.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_idx/cfg_wdata write colors, size and direction; write only
//   while the block is idle. Each transfer on req yields the next pixel in
//   row-major order on pix (restart=1 returns to row 0, column 0 first).
//   An empty rectangle (zero width or height) yields no pixel.
//   last_pixel marks the final pixel; the next request starts a new frame.
// Timing:
//   For each pixel request the three color channels pass one after
//   another through a single multiply/restoring-divide unit that retires
//   one quotient bit per cycle. req.ready rises together with pix.valid,
//   so a new request is taken only once the previous pixel is finished.
//   An empty request holds req.ready low for one cycle. One request is in
//   work at a time.
// Reset and stall:
//   rst clears the counters and loads register defaults (1x1 area, black).
//   pix has an output register: a new request is taken while a pixel waits,
//   and the finished pixel is held until the previous one is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_linear_gradient_generator #(
  parameter int MAX_WIDTH = rgbgrad_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [rgbgrad_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [rgbgrad_pkg::COLOR_W-1:0]     cfg_wdata,
  rgbgrad_req_if.sink                              req,
  rgbgrad_pix_if.source                            pix
);

  localparam int WLIM = (MAX_WIDTH < rgbgrad_pkg::AW_MAX) ? MAX_WIDTH : rgbgrad_pkg::AW_MAX;
  localparam int CW   = (WLIM > 1) ? $clog2(WLIM) : 1;

  localparam int AW = rgbgrad_pkg::AW_W;
  localparam int AH = rgbgrad_pkg::AH_W;

  // configuration
  logic [rgbgrad_pkg::COLOR_W-1:0] top_color, bottom_color;
  logic [AW-1:0]                   area_width;
  logic [AH-1:0]                   area_height;
  logic                            direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_color    <= '0;
      bottom_color <= '0;
      area_width   <= AW'(1);
      area_height  <= AH'(1);
      direction    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rgbgrad_pkg::REG_TOP_COLOR:    top_color    <= cfg_wdata;
        rgbgrad_pkg::REG_BOTTOM_COLOR: bottom_color <= cfg_wdata;
        rgbgrad_pkg::REG_AREA_WIDTH:   area_width   <= cfg_wdata[AW-1:0];
        rgbgrad_pkg::REG_AREA_HEIGHT:  area_height  <= cfg_wdata[AH-1:0];
        rgbgrad_pkg::REG_DIRECTION:    direction    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  rgbgrad_pkg::gen_state_t state, state_next;
  rgbgrad_pkg::chan_t      ch;

  logic [CW-1:0]  col;
  logic [AH-1:0]  row;
  logic           restart;
  logic [CW-1:0]  cur_col;
  logic [AH-1:0]  cur_row;
  logic           cur_last;
  logic [AW-1:0]  pix_i, pix_n;
  logic [rgbgrad_pkg::CH5_W-1:0] red, blue;
  logic [rgbgrad_pkg::CH_W-1:0]  green;

  logic           out_valid;
  logic [rgbgrad_pkg::COLOR_W-1:0]   out_color;
  logic [rgbgrad_pkg::COL_OUT_W-1:0] out_col;
  logic [AH-1:0]  out_row;
  logic           out_last;

  rgbgrad_pkg::lerp_req_t lreq;
  rgbgrad_pkg::lerp_rsp_t lrsp;

  // position of the pixel to emit
  logic [AW-1:0] w_eff;
  logic          empty, wrap;
  logic [CW-1:0] col_base, c;
  logic [AH-1:0] row_base, r;
  logic [AW-1:0] c10;
  logic [AW:0]   c_inc;
  logic [AH:0]   r_inc;
  logic          emit_ok;
  logic [rgbgrad_pkg::CH_W-1:0] ch_val;

  assign w_eff    = (area_width > AW'(WLIM)) ? AW'(WLIM) : area_width;
  assign empty    = (w_eff == '0) || (area_height == '0);
  assign col_base = restart ? '0 : col;
  assign row_base = restart ? '0 : row;
  assign wrap     = (AW'(col_base) >= w_eff) || (row_base >= area_height);
  assign c        = wrap ? '0 : col_base;
  assign r        = wrap ? '0 : row_base;
  assign c10      = AW'(c);
  assign c_inc    = (AW+1)'(c10) + 1'b1;
  assign r_inc    = (AH+1)'(r) + 1'b1;
  assign emit_ok  = !out_valid || pix.ready;
  assign ch_val   = lrsp.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rgbgrad_pkg::G_IDLE;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rgbgrad_pkg::G_PREP) begin
        if (empty) begin
          col <= col_base;
          row <= row_base;
        end else if (c_inc >= (AW+1)'(w_eff)) begin
          col <= '0;
          row <= (r_inc >= (AH+1)'(area_height)) ? '0 : r_inc[AH-1:0];
        end else begin
          col <= c_inc[CW-1:0];
          row <= r;
        end
      end
      if (state == rgbgrad_pkg::G_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      restart <= req.restart;
    end
    unique case (state)
      rgbgrad_pkg::G_PREP: begin
        cur_col  <= c;
        cur_row  <= r;
        cur_last <= (c10 == w_eff - 1'b1) && (r == area_height - 1'b1);
        pix_i    <= direction ? c10 : AW'(r);
        pix_n    <= direction ? w_eff : AW'(area_height);
        ch       <= rgbgrad_pkg::CH_RED;
      end
      rgbgrad_pkg::G_WAIT: begin
        if (lrsp.done) begin
          unique case (ch)
            rgbgrad_pkg::CH_RED: begin
              red <= ch_val[rgbgrad_pkg::CH5_W-1:0];
              ch  <= rgbgrad_pkg::CH_GREEN;
            end
            rgbgrad_pkg::CH_GREEN: begin
              green <= ch_val;
              ch    <= rgbgrad_pkg::CH_BLUE;
            end
            rgbgrad_pkg::CH_BLUE: blue <= ch_val[rgbgrad_pkg::CH5_W-1:0];
            default: ;
          endcase
        end
      end
      rgbgrad_pkg::G_EMIT: begin
        if (emit_ok) begin
          out_color <= {red, green, blue};
          out_col   <= rgbgrad_pkg::COL_OUT_W'(cur_col);
          out_row   <= cur_row;
          out_last  <= cur_last;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rgbgrad_pkg::G_IDLE:  if (req.valid) state_next = rgbgrad_pkg::G_PREP;
      rgbgrad_pkg::G_PREP:  state_next = empty ? rgbgrad_pkg::G_IDLE : rgbgrad_pkg::G_ISSUE;
      rgbgrad_pkg::G_ISSUE: state_next = rgbgrad_pkg::G_WAIT;
      rgbgrad_pkg::G_WAIT: begin
        if (lrsp.done) begin
          state_next = (ch == rgbgrad_pkg::CH_BLUE) ? rgbgrad_pkg::G_EMIT
                                                     : rgbgrad_pkg::G_ISSUE;
        end
      end
      rgbgrad_pkg::G_EMIT:  if (emit_ok) state_next = rgbgrad_pkg::G_IDLE;
      default: state_next = rgbgrad_pkg::G_IDLE;
    endcase
  end

  assign lreq.go = (state == rgbgrad_pkg::G_ISSUE);
  assign lreq.a  = rgbgrad_pkg::chan_field(top_color, ch);
  assign lreq.b  = rgbgrad_pkg::chan_field(bottom_color, ch);
  assign lreq.i  = pix_i;
  assign lreq.n  = pix_n;

  rgbgrad_lerp u_lerp (
    .clk (clk),
    .rst (rst),
    .req (lreq),
    .rsp (lrsp)
  );

  assign req.ready       = (state == rgbgrad_pkg::G_IDLE);
  assign pix.valid       = out_valid;
  assign pix.pixel_color = out_color;
  assign pix.column      = out_col;
  assign pix.row         = out_row;
  assign pix.last_pixel  = out_last;

endmodule

`default_nettype wire

### sv/rgbgrad_chk.sv
// ----------------------------------------------------------------------------
// rgbgrad_chk
// Port-level checks for the gradient generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb565_linear_gradient_generator_defines.svh"

module rgbgrad_chk (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                req_valid,
  input wire logic                                req_ready,
  input wire logic                                pix_valid,
  input wire logic                                pix_ready,
  input wire logic [rgbgrad_pkg::COLOR_W-1:0]     pixel_color,
  input wire logic [rgbgrad_pkg::COL_OUT_W-1:0]   column,
  input wire logic [rgbgrad_pkg::AH_W-1:0]        row,
  input wire logic                                last_pixel
);

  logic [rgbgrad_pkg::COLOR_W+rgbgrad_pkg::COL_OUT_W+rgbgrad_pkg::AH_W:0] payload;
  logic req_xfer, pix_stall;

  assign payload   = {pixel_color, column, row, last_pixel};
  assign req_xfer  = req_valid && req_ready;
  assign pix_stall = pix_valid && !pix_ready;

  // one request in work at a time
  `RGBGRAD_ASSERT_NEXT(a_busy_after_req, req_xfer, !req_ready, "ready after request transfer")

  `RGBGRAD_ASSERT_NEXT(a_valid_holds, pix_stall, pix_valid, "pixel dropped while stalled")

  `RGBGRAD_ASSERT_NEXT(a_payload_holds, pix_stall, $stable(payload), "pixel changed while stalled")

  // pix_valid never rises directly after a request transfer
  `RGBGRAD_ASSERT_NOW(a_no_early_pixel, $rose(pix_valid), !$past(req_xfer), "pixel too early")

endmodule

bind rgb565_linear_gradient_generator rgbgrad_chk u_rgbgrad_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .pixel_color (pix.pixel_color),
  .column      (pix.column),
  .row         (pix.row),
  .last_pixel  (pix.last_pixel)
);

`default_nettype wire

### tb/tb_rgb565_linear_gradient_generator.sv
// ----------------------------------------------------------------------------
// tb_rgb565_linear_gradient_generator
// Self-checking bench for the RGB565 gradient generator. A directed part
// covers reset defaults, color extremes, both directions, width clamping,
// empty rectangles, restart, an unused register index and a mid-frame
// resize. Random phases with fresh settings and random stalls on both
// channels follow. Every accepted request is run through a local model of
// the gradient, and each pixel transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_rgb565_linear_gradient_generator;
  import rgbgrad_pkg::*;

  localparam int FRAME_W_LIMIT = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 3'd6;

  typedef struct packed {
    logic [COLOR_W-1:0]   color;
    logic [COL_OUT_W-1:0] column;
    logic [AH_W-1:0]      row;
    logic                 last;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [COLOR_W-1:0]   cfg_wdata = '0;

  rgbgrad_req_if req_ch ();
  rgbgrad_pix_if pix_ch ();

  rgb565_linear_gradient_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .pix       (pix_ch)
  );

  always #2 clk = ~clk;

  // gradient model: registers and frame position
  logic [COLOR_W-1:0] grad_top = '0;
  logic [COLOR_W-1:0] grad_bottom = '0;
  int                 grad_width = 1;
  int                 grad_height = 1;
  logic               grad_by_column = 1'b0;
  int                 col_pos = 0;
  int                 row_pos = 0;

  logic   restart_q[$];
  pixel_t pixel_q[$];
  logic   req_xfer = 1'b0;
  bit     req_busy = 1'b0;
  bit     mismatch = 1'b0;
  int     quiet_cycles = 0;
  int unsigned req_gap = 0;
  int unsigned req_calm = 0;
  int unsigned pix_hold = 0;
  int unsigned pix_calm = 0;
  int unsigned stall_orders = 0;
  int unsigned stall_done = 0;

  function automatic int blend(input int a, input int b, input int i, input int n);
    return a + ((b - a) * i + n / 2) / n;
  endfunction

  function automatic bit next_pixel(input logic restart, output pixel_t px);
    int w, i, n, r, g, b;
    px = '0;
    w = (grad_width > FRAME_W_LIMIT) ? FRAME_W_LIMIT : grad_width;
    if (restart) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (w == 0 || grad_height == 0) return 1'b0;
    if (col_pos >= w || row_pos >= grad_height) begin
      col_pos = 0;
      row_pos = 0;
    end
    i = grad_by_column ? col_pos : row_pos;
    n = grad_by_column ? w : grad_height;
    r = blend(int'(grad_top[15:11]), int'(grad_bottom[15:11]), i, n);
    g = blend(int'(grad_top[10:5]), int'(grad_bottom[10:5]), i, n);
    b = blend(int'(grad_top[4:0]), int'(grad_bottom[4:0]), i, n);
    px.color  = {r[4:0], g[5:0], b[4:0]};
    px.column = col_pos[COL_OUT_W-1:0];
    px.row    = row_pos[AH_W-1:0];
    px.last   = (col_pos == w - 1) && (row_pos == grad_height - 1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= grad_height) row_pos = 0;
    end
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 30) return '1;
    return COLOR_W'($urandom);
  endfunction

  function automatic logic [AW_W-1:0] pick_width();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0: return AW_W'(511);
        1: return AW_W'(512);
        2: return AW_W'(513);
        default: return '1;
      endcase
    end
    return AW_W'($urandom_range(1, 9));
  endfunction

  function automatic logic [AH_W-1:0] pick_height();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 8) return '1;
    return AH_W'($urandom_range(1, 9));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TOP_COLOR:    grad_top = data;
      REG_BOTTOM_COLOR: grad_bottom = data;
      REG_AREA_WIDTH:   grad_width = int'(data[AW_W-1:0]);
      REG_AREA_HEIGHT:  grad_height = int'(data[AH_W-1:0]);
      REG_DIRECTION:    grad_by_column = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_requests(input int count, input int restart_pct);
    for (int k = 0; k < count; k++) restart_q.push_back($urandom_range(0, 99) < restart_pct);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (restart_q.size() != 0 || req_busy || pixel_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic new_setup(input bit write_all);
    logic [COLOR_W-1:0] wdata;
    if (write_all || $urandom_range(0, 9) < 7) write_reg(REG_TOP_COLOR, pick_color());
    if (write_all || $urandom_range(0, 9) < 7) write_reg(REG_BOTTOM_COLOR, pick_color());
    if (write_all || $urandom_range(0, 9) < 7) begin
      wdata = COLOR_W'($urandom);
      wdata[AW_W-1:0] = pick_width();
      write_reg(REG_AREA_WIDTH, wdata);
    end
    if (write_all || $urandom_range(0, 9) < 7) begin
      wdata = COLOR_W'($urandom);
      wdata[AH_W-1:0] = pick_height();
      write_reg(REG_AREA_HEIGHT, wdata);
    end
    if (write_all || $urandom_range(0, 9) < 7) write_reg(REG_DIRECTION, COLOR_W'($urandom));
  endtask

  // request driver
  always @(negedge clk) begin : req_driver
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
    end else begin
      if (req_xfer) req_busy = 1'b0;
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
          req_ch.valid <= 1'b0;
        end else if (restart_q.size() > 0) begin
          req_ch.restart <= restart_q.pop_front();
          req_ch.valid   <= 1'b1;
          req_busy = 1'b1;
          req_gap  = idle_len(req_calm);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // pixel receiver
  always @(negedge clk) begin : pix_receiver
    if (rst) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (stall_done != stall_orders) begin
        stall_done = stall_orders;
        pix_hold   = LONG_HOLD;
      end
      if (pix_hold > 0) begin
        pix_hold--;
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= 1'b1;
        pix_hold = idle_len(pix_calm);
      end
    end
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk) begin : pix_monitor
    pixel_t want;
    if (rst) begin
      req_xfer <= 1'b0;
      quiet_cycles = 0;
    end else begin
      req_xfer <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        if (next_pixel(req_ch.restart, want)) pixel_q.push_back(want);
      end
      if (pix_ch.valid && pix_ch.ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel transfer with no request pending: pixel_color %0h column %0d row %0d",
                 pix_ch.pixel_color, pix_ch.column, pix_ch.row);
          mismatch = 1'b1;
        end else begin
          want = pixel_q.pop_front();
          if (pix_ch.pixel_color !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, pix_ch.pixel_color);
            mismatch = 1'b1;
          end
          if (pix_ch.column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, pix_ch.column);
            mismatch = 1'b1;
          end
          if (pix_ch.row !== want.row) begin
            $error("row: expected %0d, got %0d", want.row, pix_ch.row);
            mismatch = 1'b1;
          end
          if (pix_ch.last_pixel !== want.last) begin
            $error("last_pixel: expected %b, got %b", want.last, pix_ch.last_pixel);
            mismatch = 1'b1;
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int random_items;
    int phase;
    int count;
    logic [COLOR_W-1:0] wdata;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: 1x1 black frame
    add_requests(2, 0);
    wait_drained();
    write_reg(REG_TOP_COLOR, '1);
    write_reg(REG_BOTTOM_COLOR, '0);
    write_reg(REG_AREA_WIDTH, 16'd2);
    write_reg(REG_AREA_HEIGHT, 16'd3);
    add_requests(5, 0);
    restart_q.push_back(1'b1);
    wait_drained();

    // unused index, then column mode with clamped width
    write_reg(SPARE_IDX, '1);
    write_reg(REG_TOP_COLOR, '0);
    write_reg(REG_BOTTOM_COLOR, '1);
    write_reg(REG_AREA_WIDTH, 16'd1023);
    write_reg(REG_AREA_HEIGHT, 16'd1);
    write_reg(REG_DIRECTION, 16'd1);
    add_requests(3, 0);
    restart_q.push_back(1'b1);
    wait_drained();

    // empty rectangles
    write_reg(REG_AREA_WIDTH, 16'd0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    wait_drained();
    write_reg(REG_AREA_WIDTH, 16'd5);
    write_reg(REG_AREA_HEIGHT, 16'd0);
    restart_q.push_back(1'b0);
    wait_drained();

    // resize mid-frame: position falls outside and the frame restarts
    write_reg(REG_TOP_COLOR, 16'hF81F);
    write_reg(REG_BOTTOM_COLOR, 16'h07E0);
    write_reg(REG_AREA_WIDTH, 16'd4);
    write_reg(REG_AREA_HEIGHT, 16'd4);
    write_reg(REG_DIRECTION, 16'd0);
    add_requests(6, 0);
    wait_drained();
    write_reg(REG_AREA_WIDTH, 16'd2);
    add_requests(2, 0);
    wait_drained();

    // full-width column sweep
    write_reg(REG_TOP_COLOR, pick_color());
    write_reg(REG_BOTTOM_COLOR, pick_color());
    wdata = COLOR_W'($urandom);
    wdata[AW_W-1:0] = AW_W'(512);
    write_reg(REG_AREA_WIDTH, wdata);
    write_reg(REG_AREA_HEIGHT, 16'd2);
    write_reg(REG_DIRECTION, 16'd1);
    add_requests(530, 0);
    random_items = 530;

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_drained();
      new_setup(phase == 0);
      if (grad_height == 255 && grad_width < 4) count = $urandom_range(200, 300);
      else count = $urandom_range(10, 60);
      if (phase % 9 == 4) begin
        stall_orders++;
        if (count < 30) count = 30;
      end
      add_requests(count, 4);
      random_items += count;
      phase++;
    end
    wait_drained();

    if (!mismatch) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
